### design/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg: shared definitions for the frustum culling test block
// Defaults, opcode and verdict codes, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int COEF_WIDTH_DEF  = 32;

  // Field widths fixed by the interface.
  localparam int OPCODE_W      = 2;
  localparam int PLANE_IDX_W   = 3;
  localparam int DATA_W        = 32;
  localparam int EPS_W         = 16;
  localparam int VERDICT_W     = 2;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

  // Item codes.
  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SPHERE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_BOX    = 2'd2;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_INSIDE  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_OVERLAP = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE = 2'd2;

  typedef struct packed {
    logic                   load;      // write one plane from the input ports
    logic                   capture;   // latch a test item and clear the flags
    logic                   is_box;    // test kind of the captured item
    logic                   issue;     // start one plane through the pipeline
    logic [PLANE_IDX_W-1:0] plane_sel; // plane being issued
    logic                   deliver;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic busy; // planes still in flight in the pipeline
  } status_t;

endpackage

### design/frustum_cull_test.sv
// ----------------------------------------------------------------------------
// frustum_cull_test: view frustum culling for spheres and boxes
// Keeps a set of frustum planes and classifies spheres and axis-aligned
// boxes as inside, overlapping or outside the frustum.
// ----------------------------------------------------------------------------
// Usage. Items enter on the in_ channel (valid/ready). A load item writes one
// plane's coefficients (an index beyond the store is ignored) and gives no
// result. A sphere or box test item gives one verdict transaction on the out_
// channel (valid/ready); an item with the unused opcode is dropped.
// A test walks the planes one per cycle through a shared pair of three-way
// dot products (near and far point), followed by a compare stage and the flag
// update; the verdict then lands in the output register, and the block takes
// no new item until it has done so.
// The output register parts the two sides: a new item is taken while an old
// verdict still waits. If the receiver stalls long enough for a second
// verdict to finish, the block holds it and takes no further item until the
// first one is taken.
// Reset (rst_n low at a clock edge) clears all planes to zero, sets epsilon
// to its default and empties the output. The user writes epsilon via cfg_we
// and cfg_wdata only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module frustum_cull_test #(
  parameter int PLANE_COUNT = fct_pkg::PLANE_COUNT_DEF,
  parameter int COEF_WIDTH  = fct_pkg::COEF_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [fct_pkg::OPCODE_W-1:0]          in_opcode,
  input  logic [fct_pkg::PLANE_IDX_W-1:0]       in_plane_index,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_coef_a,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_coef_b,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_coef_c,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_coef_d,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_x_lo,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_y_lo,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_z_lo,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_x_hi,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_y_hi,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_z_hi,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [fct_pkg::VERDICT_W-1:0]         out_verdict,
  input  logic                                  cfg_we,
  input  logic [fct_pkg::EPS_W-1:0]             cfg_wdata
);

  // Commands flow from the controller to the datapath; the datapath reports
  // back only whether planes are still in flight.
  fct_pkg::cmd_t    cmd;
  fct_pkg::status_t status;

  // The controller owns the handshakes and the plane sequence.
  fct_ctrl #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the planes, epsilon, the distance pipeline and the
  // verdict register.
  fct_datapath #(
    .PLANE_COUNT (PLANE_COUNT),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_plane_index (in_plane_index),
    .in_coef_a      (in_coef_a),
    .in_coef_b      (in_coef_b),
    .in_coef_c      (in_coef_c),
    .in_coef_d      (in_coef_d),
    .in_x_lo        (in_x_lo),
    .in_y_lo        (in_y_lo),
    .in_z_lo        (in_z_lo),
    .in_x_hi        (in_x_hi),
    .in_y_hi        (in_y_hi),
    .in_z_hi        (in_z_hi),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_verdict    (out_verdict),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

### design/fct_ctrl.sv
// ----------------------------------------------------------------------------
// fct_ctrl: sequencing controller
// Takes items, walks the planes through the datapath one per cycle and hands
// each verdict to the result register.
// ----------------------------------------------------------------------------
module fct_ctrl #(
  parameter int PLANE_COUNT = fct_pkg::PLANE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fct_pkg::OPCODE_W-1:0]    in_opcode,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fct_pkg::cmd_t                   cmd,
  input  fct_pkg::status_t                status
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  localparam logic [fct_pkg::PLANE_IDX_W-1:0] LAST_PLANE =
    fct_pkg::PLANE_IDX_W'(PLANE_COUNT - 1);

  state_t                            state_r, state_nxt;
  logic [fct_pkg::PLANE_IDX_W-1:0]   cnt_r, cnt_nxt;
  logic                              is_box_r, is_box_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              accept;
  logic                              out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    is_box_nxt    = is_box_r;
    cmd           = '0;
    cmd.is_box    = is_box_r;
    cmd.plane_sel = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            fct_pkg::OP_LOAD: begin
              cmd.load = 1'b1;
            end
            fct_pkg::OP_SPHERE, fct_pkg::OP_BOX: begin
              cmd.capture = 1'b1;
              cmd.is_box  = (in_opcode == fct_pkg::OP_BOX);
              is_box_nxt  = (in_opcode == fct_pkg::OP_BOX);
              cnt_nxt     = '0;
              state_nxt   = ST_RUN;
            end
            default: begin
              // Unused code: the item is dropped.
            end
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (cnt_r == LAST_PLANE) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status.busy && out_free) begin
          cmd.deliver = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.deliver) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      is_box_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      is_box_r    <= is_box_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/fct_datapath.sv
// ----------------------------------------------------------------------------
// fct_datapath: plane store and distance pipeline
// Holds the planes and epsilon, computes near and far plane distances for
// one plane a cycle in three stages and keeps the outside and overlap flags.
// ----------------------------------------------------------------------------
module fct_datapath #(
  parameter int PLANE_COUNT = fct_pkg::PLANE_COUNT_DEF,
  parameter int COEF_WIDTH  = fct_pkg::COEF_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [fct_pkg::PLANE_IDX_W-1:0]       in_plane_index,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_coef_a,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_coef_b,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_coef_c,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_coef_d,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_x_lo,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_y_lo,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_z_lo,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_x_hi,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_y_hi,
  input  logic signed [fct_pkg::DATA_W-1:0]     in_z_hi,
  input  logic                                  cfg_we,
  input  logic [fct_pkg::EPS_W-1:0]             cfg_wdata,
  output logic [fct_pkg::VERDICT_W-1:0]         out_verdict,
  input  fct_pkg::cmd_t                         cmd,
  output fct_pkg::status_t                      status
);

  localparam int DW      = fct_pkg::DATA_W;
  // Inputs are only DW bits wide, so a wider coefficient never needs more.
  localparam int STORE_W = (COEF_WIDTH < DW) ? COEF_WIDTH : DW;
  localparam int PIDX_W  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int PROD_W  = STORE_W + DW;
  localparam int THR_W   = DW + 2;
  localparam int DT_W    = THR_W + 1;
  localparam int SUM_W   = PROD_W + 4;
  localparam int EPSS_W  = fct_pkg::EPS_W + 1;
  localparam int CMP_W   = (STORE_W > EPSS_W) ? STORE_W : EPSS_W;

  localparam logic signed [DW-1:0] SAT_HI = DW'((64'sd1 <<< (STORE_W - 1)) - 64'sd1);
  localparam logic signed [DW-1:0] SAT_LO = -SAT_HI - DW'(1);

  function automatic logic signed [STORE_W-1:0] sat_coef(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] r;
    begin
      r = v;
      if (v > SAT_HI) begin
        r = SAT_HI;
      end else if (v < SAT_LO) begin
        r = SAT_LO;
      end
      return STORE_W'(r);
    end
  endfunction

  // Plane store, one row of coefficients per plane.
  logic signed [STORE_W-1:0] a_r [PLANE_COUNT];
  logic signed [STORE_W-1:0] b_r [PLANE_COUNT];
  logic signed [STORE_W-1:0] c_r [PLANE_COUNT];
  logic signed [STORE_W-1:0] d_r [PLANE_COUNT];

  logic [fct_pkg::EPS_W-1:0] eps_r;

  // Captured test item.
  logic signed [DW-1:0] xl_r, yl_r, zl_r, xh_r, yh_r, zh_r;
  logic                 box_r;

  // Stage one: products and offset minus threshold, per lane.
  logic signed [PROD_W-1:0] pxn_r, pyn_r, pzn_r, pxf_r, pyf_r, pzf_r;
  logic signed [DT_W-1:0]   dtn_r, dtf_r;
  logic                     v1_r;
  // Stage two: below-threshold flags.
  logic                     bn_r, bf_r, v2_r;
  // Accumulated flags.
  logic                     outside_r, overlap_r;
  logic [fct_pkg::VERDICT_W-1:0] verdict_nxt, out_verdict_r;

  logic [PIDX_W-1:0]         sel;
  logic                      load_ok;
  logic signed [STORE_W-1:0] qa, qb, qc, qd;
  logic signed [CMP_W-1:0]   eps_c;
  logic signed [THR_W-1:0]   thr_n, thr_f;
  logic signed [DW-1:0]      nx, ny, nz, fx, fy, fz;
  logic                      sa, sb, sc;
  logic signed [SUM_W-1:0]   sum_n, sum_f;

  assign sel     = cmd.plane_sel[PIDX_W-1:0];
  assign load_ok = (32'(in_plane_index) < PLANE_COUNT);
  assign qa = a_r[sel];
  assign qb = b_r[sel];
  assign qc = c_r[sel];
  assign qd = d_r[sel];
  assign eps_c = CMP_W'($signed({1'b0, eps_r}));

  always_comb begin
    sa = (CMP_W'(qa) < eps_c);
    sb = (CMP_W'(qb) < eps_c);
    sc = (CMP_W'(qc) < eps_c);
    if (box_r) begin
      nx = sa ? xl_r : xh_r;
      ny = sb ? yl_r : yh_r;
      nz = sc ? zl_r : zh_r;
      fx = sa ? xh_r : xl_r;
      fy = sb ? yh_r : yl_r;
      fz = sc ? zh_r : zl_r;
      thr_n = THR_W'($signed({1'b0, eps_r}));
      thr_f = thr_n;
    end else begin
      nx = xl_r;
      ny = yl_r;
      nz = zl_r;
      fx = xl_r;
      fy = yl_r;
      fz = zl_r;
      thr_n = -THR_W'(xh_r);
      thr_f = THR_W'(xh_r);
    end
  end

  assign sum_n = SUM_W'(pxn_r) + SUM_W'(pyn_r) + SUM_W'(pzn_r) + (SUM_W'(dtn_r) <<< 16);
  assign sum_f = SUM_W'(pxf_r) + SUM_W'(pyf_r) + SUM_W'(pzf_r) + (SUM_W'(dtf_r) <<< 16);

  always_comb begin
    if (outside_r) begin
      verdict_nxt = fct_pkg::VERDICT_OUTSIDE;
    end else if (overlap_r) begin
      verdict_nxt = fct_pkg::VERDICT_OVERLAP;
    end else begin
      verdict_nxt = fct_pkg::VERDICT_INSIDE;
    end
  end

  assign status.busy = v1_r || v2_r;
  assign out_verdict = out_verdict_r;

  // Plane store and epsilon.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        a_r[i] <= '0;
        b_r[i] <= '0;
        c_r[i] <= '0;
        d_r[i] <= '0;
      end
      eps_r <= fct_pkg::EPS_RESET;
    end else begin
      if (cmd.load && load_ok) begin
        a_r[in_plane_index[PIDX_W-1:0]] <= sat_coef(in_coef_a);
        b_r[in_plane_index[PIDX_W-1:0]] <= sat_coef(in_coef_b);
        c_r[in_plane_index[PIDX_W-1:0]] <= sat_coef(in_coef_c);
        d_r[in_plane_index[PIDX_W-1:0]] <= sat_coef(in_coef_d);
      end
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
    end
  end

  // Item capture and pipeline payload.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xl_r  <= in_x_lo;
      yl_r  <= in_y_lo;
      zl_r  <= in_z_lo;
      xh_r  <= in_x_hi;
      yh_r  <= in_y_hi;
      zh_r  <= in_z_hi;
      box_r <= cmd.is_box;
    end
    pxn_r <= PROD_W'(qa) * PROD_W'(nx);
    pyn_r <= PROD_W'(qb) * PROD_W'(ny);
    pzn_r <= PROD_W'(qc) * PROD_W'(nz);
    pxf_r <= PROD_W'(qa) * PROD_W'(fx);
    pyf_r <= PROD_W'(qb) * PROD_W'(fy);
    pzf_r <= PROD_W'(qc) * PROD_W'(fz);
    dtn_r <= DT_W'(qd) - DT_W'(thr_n);
    dtf_r <= DT_W'(qd) - DT_W'(thr_f);
    bn_r  <= sum_n[SUM_W-1];
    bf_r  <= sum_f[SUM_W-1];
    if (cmd.deliver) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  // Pipeline control and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      outside_r <= 1'b0;
      overlap_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.capture) begin
        outside_r <= 1'b0;
        overlap_r <= 1'b0;
      end else if (v2_r) begin
        outside_r <= outside_r || bn_r;
        overlap_r <= overlap_r || bf_r;
      end
    end
  end

endmodule

### verif/tb_frustum_cull_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_cull_test: self-checking bench for the frustum culling unit
// Drives load, sphere and box transactions with random pacing on both sides.
// A behavioural model of the plane store and epsilon register predicts each
// verdict, and every verdict transaction is checked in order against it.
// ----------------------------------------------------------------------------
module tb_frustum_cull_test;

  localparam int OPCODE_W       = fct_pkg::OPCODE_W;
  localparam int PLANE_IDX_W    = fct_pkg::PLANE_IDX_W;
  localparam int DATA_W         = fct_pkg::DATA_W;
  localparam int EPS_W          = fct_pkg::EPS_W;
  localparam int VERDICT_W      = fct_pkg::VERDICT_W;

  localparam int PLANES         = fct_pkg::PLANE_COUNT_DEF;
  localparam int COEF_W         = fct_pkg::COEF_WIDTH_DEF;
  localparam int UNIT           = 65536;                // 1.0 in Q16.16
  localparam int TEST_LATENCY   = PLANES + 4;           // acceptance to next item
  localparam int SETTLE_CYCLES  = 2 * TEST_LATENCY;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_CHUNK   = 300;
  localparam int EPS_PHASES     = 5;
  localparam int DIR_ROWS       = 25;

  // The block has no name for the spare opcode; it must simply be dropped.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] Z     = '0;
  localparam logic signed [DATA_W-1:0] U1    = 32'sd65536;
  localparam logic signed [DATA_W-1:0] U2    = 32'sd131072;
  localparam logic signed [DATA_W-1:0] U3    = 32'sd196608;
  localparam logic signed [DATA_W-1:0] U10   = 32'sd655360;
  localparam logic signed [DATA_W-1:0] P_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] N_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [PLANE_IDX_W-1:0]   plane_index;
    logic signed [DATA_W-1:0] coef_a, coef_b, coef_c, coef_d;
    logic signed [DATA_W-1:0] x_lo, y_lo, z_lo, x_hi, y_hi, z_hi;
  } cull_item_t;

  typedef struct packed {
    cull_item_t           item;
    logic                 known;   // verdict below is typed in, not predicted
    logic [VERDICT_W-1:0] verdict;
  } dir_row_t;

  // Directed table. The first rows run against the all-zero plane store left
  // by reset, where every distance is zero, so their verdicts are obvious:
  // a zero radius is inside, a positive one overlaps, a negative one is
  // outside, and a point box is outside because zero lies below epsilon.
  // The verdict column of rows with known low is not used.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{fct_pkg::OP_SPHERE, 3'd0, Z, Z, Z, Z, Z, Z, Z, Z, Z, Z}, 1'b1,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_SPHERE, 3'd0, Z, Z, Z, Z, Z, Z, Z, U1, Z, Z}, 1'b1,
      fct_pkg::VERDICT_OVERLAP},
    '{'{fct_pkg::OP_SPHERE, 3'd0, Z, Z, Z, Z, Z, Z, Z, -U1, Z, Z}, 1'b1,
      fct_pkg::VERDICT_OUTSIDE},
    '{'{fct_pkg::OP_BOX, 3'd0, Z, Z, Z, Z, Z, Z, Z, Z, Z, Z}, 1'b1,
      fct_pkg::VERDICT_OUTSIDE},
    // Spare opcode and loads to planes beyond the store: all dropped.
    '{'{OP_UNUSED, 3'd0, U1, U1, U1, U1, U1, U1, U1, U1, U1, U1}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_LOAD, 3'd6, U1, Z, Z, U10, U1, U1, U1, U1, U1, U1}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_LOAD, 3'd7, -U1, U1, Z, -U10, Z, Z, Z, Z, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_SPHERE, 3'd0, Z, Z, Z, Z, Z, Z, Z, Z, Z, Z}, 1'b1,
      fct_pkg::VERDICT_INSIDE},
    // An axis-aligned cube of half-size two units.
    '{'{fct_pkg::OP_LOAD, 3'd0, U1, Z, Z, U2, Z, Z, Z, Z, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_LOAD, 3'd1, -U1, Z, Z, U2, Z, Z, Z, Z, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_LOAD, 3'd2, Z, U1, Z, U2, Z, Z, Z, Z, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_LOAD, 3'd3, Z, -U1, Z, U2, Z, Z, Z, Z, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_LOAD, 3'd4, Z, Z, U1, U2, Z, Z, Z, Z, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_LOAD, 3'd5, Z, Z, -U1, U2, Z, Z, Z, Z, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_SPHERE, 3'd0, Z, Z, Z, Z, Z, Z, Z, U1, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_SPHERE, 3'd0, Z, Z, Z, Z, U2, Z, Z, U1, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_SPHERE, 3'd0, Z, Z, Z, Z, U10, Z, Z, U1, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_BOX, 3'd0, Z, Z, Z, Z, -U1, -U1, -U1, U1, U1, U1}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_BOX, 3'd0, Z, Z, Z, Z, U1, -U1, -U1, U3, U1, U1}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_BOX, 3'd0, Z, Z, Z, Z, U3, U3, U3, -U3, -U3, -U3}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    // Coefficient and coordinate extremes.
    '{'{fct_pkg::OP_LOAD, 3'd0, P_MAX, N_MIN, Z, N_MIN, Z, Z, Z, Z, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_SPHERE, 3'd0, Z, Z, Z, Z, P_MAX, N_MIN, P_MAX, N_MIN, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_BOX, 3'd0, Z, Z, Z, Z, N_MIN, N_MIN, N_MIN, P_MAX, P_MAX, P_MAX},
      1'b0, fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_BOX, 3'd0, Z, Z, Z, Z, P_MAX, P_MAX, P_MAX, N_MIN, N_MIN, N_MIN},
      1'b0, fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::OP_SPHERE, 3'd0, Z, Z, Z, Z, Z, Z, Z, P_MAX, Z, Z}, 1'b0,
      fct_pkg::VERDICT_INSIDE}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [OPCODE_W-1:0]      in_opcode;
  logic [PLANE_IDX_W-1:0]   in_plane_index;
  logic signed [DATA_W-1:0] in_coef_a, in_coef_b, in_coef_c, in_coef_d;
  logic signed [DATA_W-1:0] in_x_lo, in_y_lo, in_z_lo, in_x_hi, in_y_hi, in_z_hi;
  logic                     out_valid;
  logic                     out_ready;
  logic [VERDICT_W-1:0]     out_verdict;
  logic                     cfg_we;
  logic [EPS_W-1:0]         cfg_wdata;

  // Shadow of the block's state, kept in step with every accepted transaction.
  longint                   plane_coef [PLANES][4];
  logic [EPS_W-1:0]         eps_shadow;
  logic [VERDICT_W-1:0]     pending_verdicts [$];

  int mismatches;
  int items_accepted;
  int tests_sent;
  int dropped_items;
  int eps_writes;
  int verdict_seen [4];
  int in_quiet;
  int out_quiet;
  int idle_cycles;

  frustum_cull_test dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_plane_index (in_plane_index),
    .in_coef_a      (in_coef_a),
    .in_coef_b      (in_coef_b),
    .in_coef_c      (in_coef_c),
    .in_coef_d      (in_coef_d),
    .in_x_lo        (in_x_lo),
    .in_y_lo        (in_y_lo),
    .in_z_lo        (in_z_lo),
    .in_x_hi        (in_x_hi),
    .in_y_hi        (in_y_hi),
    .in_z_hi        (in_z_hi),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_verdict    (out_verdict),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Stored coefficients are clamped to the signed coefficient width.
  function automatic longint clamp_coef(longint v);
    longint top;
    top = (longint'(1) <<< (COEF_W - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  // True when the point lies strictly below thr on plane p. The sum is formed
  // exactly in 128 bits, so the Q32.32 distance never wraps or rounds.
  function automatic logic under_plane(int p, longint x, longint y, longint z,
                                       longint thr);
    logic signed [127:0] plane_dist;
    plane_dist = plane_coef[p][0] * x + plane_coef[p][1] * y + plane_coef[p][2] * z
               + plane_coef[p][3] * 65536 - thr * 65536;
    return plane_dist < 0;
  endfunction

  function automatic logic [VERDICT_W-1:0] classify_volume(cull_item_t it);
    longint xl, yl, zl, xh, yh, zh, eps;
    longint nx, ny, nz, fx, fy, fz;
    logic   partial;
    xl = it.x_lo;
    yl = it.y_lo;
    zl = it.z_lo;
    xh = it.x_hi;
    yh = it.y_hi;
    zh = it.z_hi;
    eps = longint'(eps_shadow);
    partial = 1'b0;
    for (int p = 0; p < PLANES; p++) begin
      if (it.opcode == fct_pkg::OP_SPHERE) begin
        // The radius is used as given, negative or not.
        if (under_plane(p, xl, yl, zl, -xh)) return fct_pkg::VERDICT_OUTSIDE;
        if (under_plane(p, xl, yl, zl, xh)) partial = 1'b1;
      end else begin
        // Near and far corners follow the sign of each coefficient against
        // epsilon; an inverted box is taken just as it comes.
        nx = (plane_coef[p][0] < eps) ? xl : xh;
        fx = (plane_coef[p][0] < eps) ? xh : xl;
        ny = (plane_coef[p][1] < eps) ? yl : yh;
        fy = (plane_coef[p][1] < eps) ? yh : yl;
        nz = (plane_coef[p][2] < eps) ? zl : zh;
        fz = (plane_coef[p][2] < eps) ? zh : zl;
        if (under_plane(p, nx, ny, nz, eps)) return fct_pkg::VERDICT_OUTSIDE;
        if (under_plane(p, fx, fy, fz, eps)) partial = 1'b1;
      end
    end
    return partial ? fct_pkg::VERDICT_OVERLAP : fct_pkg::VERDICT_INSIDE;
  endfunction

  // Applies one accepted transaction to the shadow state and queues the
  // verdict it should produce, if any.
  function automatic void record_item(cull_item_t it, logic known,
                                      logic [VERDICT_W-1:0] typed);
    items_accepted++;
    case (it.opcode)
      fct_pkg::OP_LOAD: begin
        if (it.plane_index < PLANES) begin
          plane_coef[it.plane_index][0] = clamp_coef(longint'(it.coef_a));
          plane_coef[it.plane_index][1] = clamp_coef(longint'(it.coef_b));
          plane_coef[it.plane_index][2] = clamp_coef(longint'(it.coef_c));
          plane_coef[it.plane_index][3] = clamp_coef(longint'(it.coef_d));
        end else begin
          dropped_items++;
        end
      end
      fct_pkg::OP_SPHERE, fct_pkg::OP_BOX: begin
        tests_sent++;
        pending_verdicts.push_back(known ? typed : classify_volume(it));
      end
      default: dropped_items++;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  always @(posedge clk) begin : verdict_check
    logic [VERDICT_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      verdict_seen[out_verdict]++;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("verdict %0d arrived with none outstanding",
                                out_verdict));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_verdict !== want)
          flag_mismatch($sformatf("verdict mismatch: expected %0d, got %0d",
                                  want, out_verdict));
      end
    end
  end

  // The watchdog only counts cycles in which neither channel completes a
  // transaction, so a steady but slow run never trips it.
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no transaction for %0d cycles, %0d verdicts outstanding",
             WATCHDOG_LIMIT, pending_verdicts.size());
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Pacing
  // --------------------------------------------------------------------------

  // Gap before the next transaction on one side. Now and then a side goes
  // quiet for a run of back-to-back transactions so that full rate is seen.
  function automatic int draw_wait(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // The receiver stalls a random number of cycles before each verdict and
  // then holds ready high until a verdict transaction completes.
  initial begin : verdict_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(out_quiet);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Presents one item after a random gap and holds it until accepted. When
  // there is no gap, valid simply stays high into the next item.
  task automatic send_item(input cull_item_t it, input logic known,
                           input logic [VERDICT_W-1:0] typed);
    int gap;
    gap = draw_wait(in_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode      <= it.opcode;
    in_plane_index <= it.plane_index;
    in_coef_a      <= it.coef_a;
    in_coef_b      <= it.coef_b;
    in_coef_c      <= it.coef_c;
    in_coef_d      <= it.coef_d;
    in_x_lo        <= it.x_lo;
    in_y_lo        <= it.y_lo;
    in_z_lo        <= it.z_lo;
    in_x_hi        <= it.x_hi;
    in_y_hi        <= it.y_hi;
    in_z_hi        <= it.z_hi;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    record_item(it, known, typed);
  endtask

  // Stops sending until every outstanding verdict has been taken, then lets
  // the pipeline settle, since a trailing load leaves nothing to wait on.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_epsilon(input logic [EPS_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    eps_shadow = value;
    eps_writes++;
  endtask

  function automatic int offset_units(int units);
    return int'($urandom_range(0, 2 * units * UNIT)) - units * UNIT;
  endfunction

  // Dominant coefficient of a plane: roughly a unit normal, either sign.
  function automatic int main_coef();
    int mag;
    mag = UNIT + int'($urandom_range(0, 16384)) - 8192;
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  // Minor coefficient: zero, a small tilt, or just around epsilon so that
  // box corner selection flips between its two choices.
  function automatic int side_coef();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return int'(eps_shadow) + int'($urandom_range(0, 4)) - 2;
      default: return int'($urandom_range(0, 16384)) - 8192;
    endcase
  endfunction

  // Most items are planes and volumes of sensible size around the frustum,
  // so that all three verdicts turn up; one in ten is raw random bits.
  function automatic cull_item_t make_item();
    cull_item_t               it;
    int unsigned              pick;
    int                       axis;
    logic signed [DATA_W-1:0] lo_c [3];
    logic signed [DATA_W-1:0] hi_c [3];
    logic signed [DATA_W-1:0] swap;
    it.plane_index = PLANE_IDX_W'($urandom);
    it.coef_a = $urandom;
    it.coef_b = $urandom;
    it.coef_c = $urandom;
    it.coef_d = $urandom;
    it.x_lo   = $urandom;
    it.y_lo   = $urandom;
    it.z_lo   = $urandom;
    it.x_hi   = $urandom;
    it.y_hi   = $urandom;
    it.z_hi   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 4) it.opcode = OP_UNUSED;
    else if (pick < 24) it.opcode = fct_pkg::OP_LOAD;
    else if (pick < 62) it.opcode = fct_pkg::OP_SPHERE;
    else it.opcode = fct_pkg::OP_BOX;
    if ($urandom_range(0, 9) == 0) return it;
    case (it.opcode)
      fct_pkg::OP_LOAD: begin
        it.plane_index = PLANE_IDX_W'($urandom_range(0, PLANES - 1));
        axis = $urandom_range(0, 2);
        it.coef_a = (axis == 0) ? main_coef() : side_coef();
        it.coef_b = (axis == 1) ? main_coef() : side_coef();
        it.coef_c = (axis == 2) ? main_coef() : side_coef();
        it.coef_d = offset_units(10);
      end
      fct_pkg::OP_SPHERE: begin
        it.x_lo = offset_units(8);
        it.y_lo = offset_units(8);
        it.z_lo = offset_units(8);
        if ($urandom_range(0, 9) == 0) it.x_hi = -int'($urandom_range(0, UNIT));
        else it.x_hi = $urandom_range(0, 4 * UNIT);
      end
      fct_pkg::OP_BOX: begin
        for (int k = 0; k < 3; k++) begin
          lo_c[k] = offset_units(8);
          hi_c[k] = lo_c[k] + int'($urandom_range(0, 4 * UNIT));
          if ($urandom_range(0, 9) == 0) begin
            swap    = lo_c[k];
            lo_c[k] = hi_c[k];
            hi_c[k] = swap;
          end
        end
        it.x_lo = lo_c[0];
        it.y_lo = lo_c[1];
        it.z_lo = lo_c[2];
        it.x_hi = hi_c[0];
        it.y_hi = hi_c[1];
        it.z_hi = hi_c[2];
      end
      default: ;
    endcase
    return it;
  endfunction

  // Sends random items until the given number of them have had an effect;
  // dropped items come along for free. Every so often the sender holds off
  // until the verdict queue has emptied.
  task automatic run_random(input int count);
    cull_item_t it;
    int         counted;
    counted = 0;
    while (counted < count) begin
      if ($urandom_range(0, 249) == 0) drain_results();
      it = make_item();
      send_item(it, 1'b0, fct_pkg::VERDICT_INSIDE);
      if (it.opcode != OP_UNUSED &&
          !(it.opcode == fct_pkg::OP_LOAD && it.plane_index >= PLANES))
        counted++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin : main_sequence
    logic [EPS_W-1:0] eps_value;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = fct_pkg::OP_LOAD;
    in_plane_index = '0;
    in_coef_a      = '0;
    in_coef_b      = '0;
    in_coef_c      = '0;
    in_coef_d      = '0;
    in_x_lo        = '0;
    in_y_lo        = '0;
    in_z_lo        = '0;
    in_x_hi        = '0;
    in_y_hi        = '0;
    in_z_hi        = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    eps_shadow     = fct_pkg::EPS_RESET;
    mismatches     = 0;
    items_accepted = 0;
    tests_sent     = 0;
    dropped_items  = 0;
    eps_writes     = 0;
    in_quiet       = 0;
    out_quiet      = 0;
    for (int v = 0; v < 4; v++) verdict_seen[v] = 0;
    for (int p = 0; p < PLANES; p++)
      for (int k = 0; k < 4; k++) plane_coef[p][k] = 0;

    // Synchronous reset, released between edges.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows start from the zeroed plane store, with epsilon at reset value.
    for (int r = 0; r < DIR_ROWS; r++)
      send_item(DIRECTED[r].item, DIRECTED[r].known, DIRECTED[r].verdict);

    run_random(RANDOM_CHUNK);

    // Each further phase changes epsilon only once the block is idle: the
    // two extremes, the smallest non-zero step, then random settings.
    for (int ph = 0; ph < EPS_PHASES; ph++) begin
      drain_results();
      case (ph)
        0:       eps_value = '0;
        1:       eps_value = '1;
        2:       eps_value = 16'd1;
        default: eps_value = EPS_W'($urandom_range(2, 65534));
      endcase
      write_epsilon(eps_value);
      run_random(RANDOM_CHUNK);
    end

    drain_results();

    $display("Ran %0d items (%0d tests, %0d dropped) across %0d epsilon settings.",
             items_accepted, tests_sent, dropped_items, eps_writes + 1);
    $display("Verdicts seen: %0d inside, %0d overlap, %0d outside; %0d mismatches.",
             verdict_seen[fct_pkg::VERDICT_INSIDE], verdict_seen[fct_pkg::VERDICT_OVERLAP],
             verdict_seen[fct_pkg::VERDICT_OUTSIDE], mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
